FILE: hw/rtl/knn_mean_neighbor_distance_defines.svh
// Assertion macros for the neighbour distance block.
`ifndef KNN_MEAN_NEIGHBOR_DISTANCE_DEFINES_SVH
`define KNN_MEAN_NEIGHBOR_DISTANCE_DEFINES_SVH
// Asserts that an implication holds at every rising edge outside reset.
`define KNN_ASSERT_IMPL(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Asserts that a signal is low while reset is applied.
`define KNN_ASSERT_RST(label, clk, rst_n, sig, msg) \
  label: assert property (@(posedge clk) !rst_n |-> !(sig)) else $error(msg);
`endif

FILE: hw/rtl/knn_pkg.sv
// ----------------------------------------------------------------------------
// Neighbour distance package
// Request codes, widths and the cell control struct.
// ----------------------------------------------------------------------------
`default_nettype none
package knn_pkg;
  typedef enum logic [1:0] {
    REQ_LOAD  = 2'd0,
    REQ_QUERY = 2'd1,
    REQ_CLEAR = 2'd2,
    REQ_NONE  = 2'd3
  } req_e;

  typedef enum logic [2:0] {
    ST_IDLE, ST_FETCH, ST_SCAN, ST_DRAIN, ST_SUM, ST_DIV, ST_SQRT, ST_DONE
  } state_e;

  localparam int unsigned MeanBits = 21;
  localparam int unsigned UsedBits = 3;
  localparam int unsigned IndexBits = 10;
  localparam int unsigned DefaultSq = 15;

  typedef struct packed {
    logic clear;
    logic valid;
  } cell_ctl_t;
endpackage
`default_nettype wire

FILE: hw/rtl/knn_cell.sv
// ----------------------------------------------------------------------------
// Neighbour insertion cell
// Holds one of the sorted smallest distances and passes displaced or rejected values on.
// ----------------------------------------------------------------------------
`default_nettype none
module knn_cell #(
  parameter int unsigned DW = 25
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire knn_pkg::cell_ctl_t ctl_i,
  input  wire logic [DW-1:0]      d_i,
  input  wire logic               v_i,
  output logic      [DW-1:0]      d_o,
  output logic                    v_o,
  output logic      [DW-1:0]      held_o,
  output logic                    full_o
);
  import knn_pkg::*;
  logic [DW-1:0] held_q, held_d, out_q, out_d;
  logic full_q, full_d, ov_q, ov_d;

  always_comb begin
    held_d = held_q;
    full_d = full_q;
    out_d  = d_i;
    ov_d   = 1'b0;
    if (v_i && ctl_i.valid) begin
      if (!full_q) begin
        held_d = d_i;
        full_d = 1'b1;
      end else if (d_i < held_q) begin
        held_d = d_i;
        out_d  = held_q;
        ov_d   = 1'b1;
      end else begin
        ov_d = 1'b1;
      end
    end
    if (ctl_i.clear) begin
      full_d = 1'b0;
      ov_d   = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_q <= 1'b0;
      ov_q   <= 1'b0;
    end else begin
      full_q <= full_d;
      ov_q   <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    held_q <= held_d;
    out_q  <= out_d;
  end

  assign d_o    = out_q;
  assign v_o    = ov_q;
  assign held_o = held_q;
  assign full_o = full_q;
endmodule
`default_nettype wire

FILE: hw/rtl/knn_mean_neighbor_distance.sv
// ----------------------------------------------------------------------------
// Mean nearest neighbour distance
// Point store with a chain of insertion cells, a divider and a square root.
// ----------------------------------------------------------------------------
// A load or clear updates the point store and returns to idle via ST_DONE.
// During a query one stored point is read from the memory each cycle and its
// squared distance enters the cell chain, then a bit-serial divider and square
// root finish the result. The result strobe lasts one cycle and cannot be held
// off, and busy stays high until it has been shown.
`default_nettype none
module knn_mean_neighbor_distance #(
  parameter int unsigned MAX_POINTS = 1024,
  parameter int unsigned NEIGHBORS  = 5,
  parameter int unsigned COORD_BITS = 12
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic [1:0]                   req_type_i,
  input  wire logic [COORD_BITS-1:0]        x_coord_i,
  input  wire logic [COORD_BITS-1:0]        y_coord_i,
  input  wire logic [knn_pkg::IndexBits-1:0] point_index_i,
  output logic                              strobe,
  output logic [knn_pkg::MeanBits-1:0]      mean_distance_o,
  output logic [knn_pkg::UsedBits-1:0]      neighbors_used_o,
  output logic                              index_invalid_o
);
  import knn_pkg::*;

  localparam int unsigned AW  = $clog2(MAX_POINTS);
  localparam int unsigned CW  = AW + 1;
  localparam int unsigned DW  = 2 * COORD_BITS + 1;
  localparam int unsigned KW  = $clog2(NEIGHBORS + 1);
  localparam int unsigned SW  = DW + KW;
  localparam int unsigned NW  = SW + 16;
  localparam int unsigned RW  = NW / 2 + 1;
  localparam int unsigned QC  = NW + 1;
  localparam int unsigned TW  = $clog2(QC + 1);
  localparam int unsigned ECW = $clog2(NEIGHBORS + 1);

  logic [2*COORD_BITS-1:0] mem [MAX_POINTS];
  logic [2*COORD_BITS-1:0] rd_q;
  logic [AW-1:0] rd_addr;
  logic rd_en;

  state_e state_q, state_d;
  logic [CW-1:0] count_q, count_d, scan_q, scan_d;
  logic [AW-1:0] idx_q, idx_d;
  logic [COORD_BITS-1:0] x1_q, x1_d, y1_q, y1_d;
  logic [CW-1:0] jrd_q;
  logic vrd_q;
  logic [DW-1:0] dist_q;
  logic dv_q;
  logic [ECW-1:0] ecnt_q, ecnt_d;
  logic [SW-1:0] sum_q, sum_d;
  logic [KW-1:0] kept_q, kept_d;
  logic [NW-1:0] rem_q, rem_d, quo_q, quo_d;
  logic [TW-1:0] step_q, step_d;
  logic [NW+1:0] sr_q, sr_d;
  logic [RW-1:0] root_q, root_d;
  logic [MeanBits-1:0] mean_q, mean_d;
  logic inv_q, inv_d, strobe_q, strobe_d;
  logic [UsedBits-1:0] used_q, used_d;
  logic [2*COORD_BITS-1:0] wr_data;
  logic wr_en;
  logic [AW-1:0] wr_addr;
  cell_ctl_t ctl;

  logic [DW-1:0] cd [NEIGHBORS+1];
  logic cv [NEIGHBORS+1];
  logic [DW-1:0] held [NEIGHBORS];
  logic full [NEIGHBORS];

  assign cd[0] = dist_q;
  assign cv[0] = dv_q;

  for (genvar g = 0; g < NEIGHBORS; g++) begin : g_cell
    knn_cell #(.DW(DW)) u_cell (
      .clk_i, .rst_ni, .ctl_i(ctl), .d_i(cd[g]), .v_i(cv[g]),
      .d_o(cd[g+1]), .v_o(cv[g+1]), .held_o(held[g]), .full_o(full[g])
    );
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  logic [COORD_BITS-1:0] x2, y2, dx, dy;
  assign x2 = rd_q[COORD_BITS-1:0];
  assign y2 = rd_q[2*COORD_BITS-1:COORD_BITS];
  assign dx = (x1_q > x2) ? x1_q - x2 : x2 - x1_q;
  assign dy = (y1_q > y2) ? y1_q - y2 : y2 - y1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_q <= 1'b0;
      vrd_q <= 1'b0;
    end else begin
      dv_q <= vrd_q && (jrd_q != {1'b0, idx_q}) && (state_q == ST_SCAN
              || state_q == ST_DRAIN);
      vrd_q <= (state_q == ST_SCAN) && (scan_q < count_q);
    end
  end

  always_ff @(posedge clk_i) begin
    jrd_q  <= scan_q;
    dist_q <= DW'(dx * dx) + DW'(dy * dy);
  end

  logic [NW:0] trial;
  logic [NW+1:0] sq_t;
  logic [KW-1:0] div_n;
  assign div_n = (kept_q == '0) ? KW'(1) : kept_q;

  always_comb begin
    state_d = state_q;
    count_d = count_q;
    scan_d  = scan_q;
    idx_d   = idx_q;
    x1_d    = x1_q;
    y1_d    = y1_q;
    ecnt_d  = ecnt_q;
    sum_d   = sum_q;
    kept_d  = kept_q;
    rem_d   = rem_q;
    quo_d   = quo_q;
    step_d  = step_q;
    sr_d    = sr_q;
    root_d  = root_q;
    mean_d  = mean_q;
    inv_d   = inv_q;
    used_d  = used_q;
    strobe_d = 1'b0;
    wr_en   = 1'b0;
    wr_addr = count_q[AW-1:0];
    wr_data = {y_coord_i, x_coord_i};
    rd_en   = 1'b0;
    rd_addr = scan_q[AW-1:0];
    ctl     = '{clear: 1'b0, valid: 1'b1};
    trial   = '0;
    sq_t    = '0;
    case (state_q)
      ST_IDLE: begin
        if (start) begin
          case (req_type_i)
            REQ_LOAD: begin
              if (count_q < CW'(MAX_POINTS)) begin
                wr_en = 1'b1;
                count_d = count_q + 1'b1;
              end
              state_d = ST_DONE;
            end
            REQ_CLEAR: begin
              count_d = '0;
              state_d = ST_DONE;
            end
            REQ_QUERY: begin
              if ({{(CW > IndexBits ? CW - IndexBits : 0){1'b0}}, point_index_i}
                  >= (IndexBits > CW ? IndexBits : CW)'(count_q)) begin
                mean_d = '0;
                used_d = '0;
                inv_d = 1'b1;
                strobe_d = 1'b1;
                state_d = ST_DONE;
              end else begin
                idx_d = AW'(point_index_i);
                rd_en = 1'b1;
                rd_addr = AW'(point_index_i);
                ctl.clear = 1'b1;
                state_d = ST_FETCH;
              end
            end
            default: state_d = ST_DONE;
          endcase
        end
      end
      ST_FETCH: begin
        x1_d = rd_q[COORD_BITS-1:0];
        y1_d = rd_q[2*COORD_BITS-1:COORD_BITS];
        scan_d = '0;
        state_d = ST_SCAN;
      end
      ST_SCAN: begin
        if (scan_q < count_q) begin
          rd_en = 1'b1;
          scan_d = scan_q + 1'b1;
        end else begin
          ecnt_d = '0;
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        ecnt_d = ecnt_q + 1'b1;
        if (ecnt_q == ECW'(NEIGHBORS)) begin
          sum_d = '0;
          kept_d = '0;
          ecnt_d = '0;
          state_d = ST_SUM;
        end
      end
      ST_SUM: begin
        if (ecnt_q == ECW'(NEIGHBORS)) begin
          if (kept_q == '0) begin
            sum_d = SW'(DefaultSq);
          end
          rem_d = '0;
          quo_d = NW'(sum_d) << 16;
          step_d = '0;
          state_d = ST_DIV;
        end else begin
          if (full[ecnt_q]) begin
            sum_d = sum_q + SW'(held[ecnt_q]);
            kept_d = kept_q + 1'b1;
          end
          ecnt_d = ecnt_q + 1'b1;
        end
      end
      ST_DIV: begin
        trial = {rem_q, quo_q[NW-1]} - {{(NW+1-KW){1'b0}}, div_n};
        if (step_q == TW'(NW)) begin
          sr_d = '0;
          root_d = '0;
          step_d = '0;
          rem_d = quo_q;
          state_d = ST_SQRT;
        end else begin
          if (!trial[NW]) begin
            rem_d = trial[NW-1:0];
            quo_d = {quo_q[NW-2:0], 1'b1};
          end else begin
            rem_d = {rem_q[NW-2:0], quo_q[NW-1]};
            quo_d = {quo_q[NW-2:0], 1'b0};
          end
          step_d = step_q + 1'b1;
        end
      end
      ST_SQRT: begin
        sq_t = {sr_q[NW-1:0], rem_q[NW-1:NW-2]}
               - {{(NW+2-RW-2){1'b0}}, root_q, 2'b01};
        if (step_q == TW'(NW / 2)) begin
          mean_d = MeanBits'(root_q);
          used_d = UsedBits'(kept_q);
          inv_d = 1'b0;
          strobe_d = 1'b1;
          state_d = ST_DONE;
        end else begin
          rem_d = {rem_q[NW-3:0], 2'b00};
          if (!sq_t[NW+1]) begin
            sr_d = sq_t;
            root_d = {root_q[RW-2:0], 1'b1};
          end else begin
            sr_d = {sr_q[NW-1:0], rem_q[NW-1:NW-2]};
            root_d = {root_q[RW-2:0], 1'b0};
          end
          step_d = step_q + 1'b1;
        end
      end
      ST_DONE: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
      strobe_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      strobe_q <= strobe_d;
    end
  end

  always_ff @(posedge clk_i) begin
    scan_q <= scan_d;
    idx_q  <= idx_d;
    x1_q   <= x1_d;
    y1_q   <= y1_d;
    ecnt_q <= ecnt_d;
    sum_q  <= sum_d;
    kept_q <= kept_d;
    rem_q  <= rem_d;
    quo_q  <= quo_d;
    step_q <= step_d;
    sr_q   <= sr_d;
    root_q <= root_d;
    mean_q <= mean_d;
    inv_q  <= inv_d;
    used_q <= used_d;
  end

  assign busy = (state_q != ST_IDLE);
  assign strobe = strobe_q;
  assign mean_distance_o = mean_q;
  assign neighbors_used_o = used_q;
  assign index_invalid_o = inv_q;
endmodule
`default_nettype wire

FILE: hw/rtl/knn_checker.sv
// ----------------------------------------------------------------------------
// Neighbour distance port checker
// Checks the result strobe and busy against each transfer on the ports.
// ----------------------------------------------------------------------------
`default_nettype none
`include "knn_mean_neighbor_distance_defines.svh"
module knn_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       start,
  input wire logic       busy,
  input wire logic       strobe,
  input wire logic [2:0] neighbors_used_o,
  input wire logic       index_invalid_o
);
  import knn_pkg::*;
  `KNN_ASSERT_IMPL(a_strobe_busy, clk_i, rst_ni, strobe |-> busy, "strobe while idle")
  `KNN_ASSERT_IMPL(a_start_busy, clk_i, rst_ni, (start && !busy) |=> busy, "no busy after start")
  `KNN_ASSERT_IMPL(a_strobe_once, clk_i, rst_ni, strobe |=> !strobe, "double strobe")
  `KNN_ASSERT_IMPL(a_invalid_used, clk_i, rst_ni,
    (strobe && index_invalid_o) |-> (neighbors_used_o == '0), "used set on bad index")
  `KNN_ASSERT_RST(a_rst_strobe, clk_i, rst_ni, strobe, "strobe in reset")
endmodule

bind knn_mean_neighbor_distance knn_checker u_knn_checker (
  .clk_i, .rst_ni, .start, .busy, .strobe, .neighbors_used_o, .index_invalid_o
);
`default_nettype wire

FILE: sim/tb.sv
// ----------------------------------------------------------------------------
// Mean nearest neighbour distance testbench
// Loads, clears and queries of the point store are driven through the start
// and busy handshake, with random idle bursts. A scoreboard predicts each
// query result from its own copy of the store and checks every strobe.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module tb;
  import knn_pkg::*;

  localparam int unsigned Capacity = 1024;
  localparam int unsigned Nearest  = 5;
  localparam int unsigned CoordW   = 12;
  localparam int unsigned CycleLimit = 3000000;

  typedef struct packed {
    logic [MeanBits-1:0] mean;
    logic [UsedBits-1:0] used;
    logic                invalid;
  } distance_t;

  class distance_scoreboard;
    logic [CoordW-1:0] xs [Capacity];
    logic [CoordW-1:0] ys [Capacity];
    int unsigned       count;
    distance_t         due_q[$];
    int unsigned       mismatches;

    function new();
      count = 0;
      mismatches = 0;
    endfunction

    function longint unsigned root(longint unsigned v);
      longint unsigned r;
      longint unsigned t;
      r = 0;
      for (int b = 31; b >= 0; b--) begin
        t = r | (64'd1 << b);
        if (t * t <= v) r = t;
      end
      return r;
    endfunction

    function void note_input(req_e req, logic [CoordW-1:0] x, logic [CoordW-1:0] y,
                             logic [IndexBits-1:0] idx);
      longint unsigned dists[$];
      longint unsigned sum;
      longint unsigned dx;
      longint unsigned dy;
      int unsigned     kept;
      distance_t       e;
      case (req)
        REQ_LOAD: begin
          if (count < Capacity) begin
            xs[count] = x;
            ys[count] = y;
            count++;
          end
        end
        REQ_CLEAR: count = 0;
        REQ_QUERY: begin
          e = '0;
          if (idx >= count) begin
            e.invalid = 1'b1;
          end else begin
            for (int j = 0; j < count; j++) begin
              if (j != idx) begin
                dx = (xs[j] > xs[idx]) ? xs[j] - xs[idx] : xs[idx] - xs[j];
                dy = (ys[j] > ys[idx]) ? ys[j] - ys[idx] : ys[idx] - ys[j];
                dists = {dists, dx * dx + dy * dy};
              end
            end
            dists.sort();
            kept = (dists.size() < Nearest) ? dists.size() : Nearest;
            sum = 0;
            for (int j = 0; j < kept; j++) sum += dists[j];
            if (kept == 0) sum = DefaultSq;
            e.mean = MeanBits'(root((sum << 16) / ((kept == 0) ? 1 : kept)));
            e.used = UsedBits'(kept);
          end
          due_q = {due_q, e};
        end
        default: ;
      endcase
    endfunction

    function void check_result(distance_t got);
      distance_t e;
      if (due_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result %h", got);
        return;
      end
      e = due_q.pop_front();
      if (got.mean !== e.mean || got.used !== e.used || got.invalid !== e.invalid) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Mismatch: expected mean %0d used %0d invalid %0d, got %0d %0d %0d",
                   e.mean, e.used, e.invalid, got.mean, got.used, got.invalid);
      end
    endfunction

    function int unsigned pending();
      return due_q.size();
    endfunction
  endclass

  logic                 clk_i;
  logic                 rst_ni;
  logic                 start;
  logic                 busy;
  logic [1:0]           req_type_i;
  logic [CoordW-1:0]    x_coord_i;
  logic [CoordW-1:0]    y_coord_i;
  logic [IndexBits-1:0] point_index_i;
  logic                 strobe;
  logic [MeanBits-1:0]  mean_distance_o;
  logic [UsedBits-1:0]  neighbors_used_o;
  logic                 index_invalid_o;

  distance_scoreboard sb = new();
  int unsigned items;
  int unsigned cycles;
  bit          quiet;

  knn_mean_neighbor_distance DUT (
    .clk_i, .rst_ni, .start, .busy, .req_type_i, .x_coord_i, .y_coord_i,
    .point_index_i, .strobe, .mean_distance_o, .neighbors_used_o, .index_invalid_o
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("tb failed");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && strobe) sb.check_result({mean_distance_o, neighbors_used_o, index_invalid_o});
  end

  task automatic transfer(req_e req, logic [CoordW-1:0] x, logic [CoordW-1:0] y,
                          logic [IndexBits-1:0] idx);
    int unsigned gap;
    req_type_i <= req;
    x_coord_i <= x;
    y_coord_i <= y;
    point_index_i <= idx;
    start <= 1'b1;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    sb.note_input(req, x, y, idx);
    items++;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 14);
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic load(logic [CoordW-1:0] x, logic [CoordW-1:0] y);
    transfer(REQ_LOAD, x, y, IndexBits'($urandom));
  endtask

  task automatic query(logic [IndexBits-1:0] idx);
    transfer(REQ_QUERY, CoordW'($urandom), CoordW'($urandom), idx);
  endtask

  task automatic random_query();
    logic [IndexBits-1:0] idx;
    if (sb.count > 0 && $urandom_range(0, 9) < 8)
      idx = IndexBits'($urandom_range(0, sb.count - 1));
    else if (sb.count < Capacity) idx = IndexBits'($urandom_range(sb.count, Capacity - 1));
    else idx = IndexBits'($urandom);
    query(idx);
  endtask

  initial begin
    int unsigned n;
    int unsigned bx;
    int unsigned by;
    cycles = 0;
    items = 0;
    quiet = 1'b0;
    rst_ni = 1'b0;
    start = 1'b0;
    req_type_i = REQ_NONE;
    x_coord_i = '0;
    y_coord_i = '0;
    point_index_i = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    query(0);
    load(0, 0);
    query(0);
    query(1);
    load(4095, 4095);
    load(4095, 0);
    load(0, 4095);
    load(0, 0);
    query(0);
    query(1);
    query(4);
    transfer(REQ_NONE, 12, 34, 0);
    load(2048, 2048);
    load(1, 1);
    query(5);
    query(1023);
    transfer(REQ_CLEAR, 0, 0, 0);
    query(0);
    load(100, 200);
    query(0);

    start <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);

    transfer(REQ_CLEAR, 0, 0, 0);
    for (int i = 0; i < 200; i++) load(CoordW'($urandom), CoordW'($urandom));
    query(1023);
    query(0);
    query(IndexBits'($urandom));

    while (items < 540) begin
      if (items > 480) quiet = 1'b1;
      if ($urandom_range(0, 3) != 0)
        transfer(REQ_CLEAR, CoordW'($urandom), CoordW'($urandom), IndexBits'($urandom));
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
      bx = $urandom;
      by = $urandom;
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(0, 2) == 0)
          load(CoordW'((bx + $urandom_range(0, 3)) % 4096),
               CoordW'((by + $urandom_range(0, 3)) % 4096));
        else
          load(CoordW'($urandom), CoordW'($urandom));
      end
      n = $urandom_range(1, 6);
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(0, 15) == 0)
          transfer(REQ_NONE, CoordW'($urandom), CoordW'($urandom), IndexBits'($urandom));
        random_query();
      end
    end

    start <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end
endmodule
`default_nettype wire

FILE: filelist.f
+incdir+hw/rtl
hw/rtl/knn_pkg.sv
hw/rtl/knn_cell.sv
hw/rtl/knn_mean_neighbor_distance.sv
hw/rtl/knn_checker.sv
sim/tb.sv
